### rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int ID_W   = 4;
  localparam int SVC_W  = 10;
  localparam int TIME_W = 16;
  localparam int Q_W    = 8;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_ARRIVE = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [SVC_W-1:0]  svc_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [Q_W-1:0]    quant_t;

  // one queue slot: process id, work left, arrival time
  typedef struct packed {
    id_t   id;
    svc_t  remaining;
    time_t arrival;
  } entry_t;

endpackage

### rtl/rrts_in_if.sv
interface rrts_in_if;
  import rrts_pkg::*;

  logic valid;
  logic ready;
  logic action;
  id_t  proc_id;
  svc_t service_time;

  modport source (output valid, output action, output proc_id, output service_time,
                  input ready);
  modport sink (input valid, input action, input proc_id, input service_time,
                output ready);
endinterface

### rtl/rrts_out_if.sv
interface rrts_out_if;
  import rrts_pkg::*;

  logic  valid;
  logic  ready;
  logic  ran;
  id_t   running_id;
  logic  finished;
  time_t finish_time;
  time_t turnaround;
  logic  queue_full;

  modport source (output valid, output ran, output running_id, output finished,
                  output finish_time, output turnaround, output queue_full,
                  input ready);
  modport sink (input valid, input ran, input running_id, input finished,
                input finish_time, input turnaround, input queue_full,
                output ready);
endinterface

### rtl/round_robin_tick_scheduler_core.sv
// an arrival or a tick on an empty queue registers its result in the cycle after acceptance;
// a tick that serves a process registers the head slot read, then writes back the slot and
// registers its result; a new request is taken only when idle, so a serving tick holds off the
// next one until its write back, and a request waits while an earlier result is not taken
// reset (rst_n low, synchronous): queue empty, time 0, quantum register 1; queue memory
// contents are not cleared, so no clearing pass is needed
module round_robin_tick_scheduler_core #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  rrts_in_if.sink             in_ch,
  rrts_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [rrts_pkg::Q_W-1:0] cfg_wdata
);
  import rrts_pkg::*;

  localparam int PTR_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_PROCESSES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_PROCESSES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  entry_t mem [MAX_PROCESSES];

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  quant_t           quantum_r;
  quant_t           qleft_r, qleft_nxt;
  time_t            now_r, now_nxt;
  entry_t           rd_r;

  logic             out_valid_r, out_valid_nxt;
  logic             ran_r, ran_nxt;
  id_t              run_id_r, run_id_nxt;
  logic             fin_r, fin_nxt;
  time_t            fin_time_r, fin_time_nxt;
  time_t            turn_r, turn_nxt;
  logic             full_r, full_nxt;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  logic             accept;
  quant_t           eff_q;
  svc_t             rem;
  quant_t           ql_dec;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign eff_q       = (quantum_r == '0) ? Q_W'(1) : quantum_r;
  assign rem         = (rd_r.remaining != '0) ? rd_r.remaining - SVC_W'(1) : '0;
  assign ql_dec      = (qleft_r != '0) ? qleft_r - Q_W'(1) : '0;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    qleft_nxt     = qleft_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ran_nxt       = ran_r;
    run_id_nxt    = run_id_r;
    fin_nxt       = fin_r;
    fin_time_nxt  = fin_time_r;
    turn_nxt      = turn_r;
    full_nxt      = full_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = '{id: in_ch.proc_id,
                      remaining: (in_ch.service_time == '0) ? SVC_W'(1) : in_ch.service_time,
                      arrival: now_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ran_nxt      = 1'b0;
          run_id_nxt   = '0;
          fin_nxt      = 1'b0;
          fin_time_nxt = '0;
          turn_nxt     = '0;
          full_nxt     = 1'b0;
          if (in_ch.action == ACT_ARRIVE) begin
            out_valid_nxt = 1'b1;
            if (count_r == FULL_CNT) begin
              full_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              tail_nxt  = next_slot(tail_r);
              count_nxt = count_r + CNT_W'(1);
              if (count_r == '0) begin
                qleft_nxt = eff_q;
              end
            end
          end else begin
            now_nxt = (now_r != TIME_MAX) ? now_r + TIME_W'(1) : TIME_MAX;
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              // head slot is read this edge, served next cycle
              state_nxt = ST_EXEC;
            end
          end
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        ran_nxt       = 1'b1;
        run_id_nxt    = rd_r.id;
        if (rem == '0) begin
          fin_nxt      = 1'b1;
          fin_time_nxt = now_r;
          turn_nxt     = now_r - rd_r.arrival;
          head_nxt     = next_slot(head_r);
          count_nxt    = count_r - CNT_W'(1);
          qleft_nxt    = eff_q;
        end else if (ql_dec == '0) begin
          // quantum used up: rotate head entry to the tail
          mem_we    = 1'b1;
          mem_waddr = tail_r;
          mem_wdata = '{id: rd_r.id, remaining: rem, arrival: rd_r.arrival};
          head_nxt  = next_slot(head_r);
          tail_nxt  = next_slot(tail_r);
          qleft_nxt = eff_q;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          mem_wdata = '{id: rd_r.id, remaining: rem, arrival: rd_r.arrival};
          qleft_nxt = ql_dec;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      quantum_r   <= Q_W'(1);
      qleft_r     <= Q_W'(1);
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      qleft_r     <= qleft_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ran_r      <= ran_nxt;
    run_id_r   <= run_id_nxt;
    fin_r      <= fin_nxt;
    fin_time_r <= fin_time_nxt;
    turn_r     <= turn_nxt;
    full_r     <= full_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ran         = ran_r;
  assign out_ch.running_id  = run_id_r;
  assign out_ch.finished    = fin_r;
  assign out_ch.finish_time = fin_time_r;
  assign out_ch.turnaround  = turn_r;
  assign out_ch.queue_full  = full_r;

endmodule

### verif/round_robin_tick_scheduler_core_test.sv
`timescale 1ns / 1ps

module round_robin_tick_scheduler_core_test;
  import rrts_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 172;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP   = 100;

  typedef struct packed {
    logic  ran;
    id_t   running_id;
    logic  finished;
    time_t finish_time;
    time_t turnaround;
    logic  queue_full;
  } sched_result_t;

  typedef struct packed {
    logic          action;
    id_t           proc_id;
    svc_t          service_time;
    logic          has_want;
    sched_result_t want;
  } stim_row_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   cfg_we;
  quant_t cfg_wdata;

  rrts_in_if  in_ch();
  rrts_out_if out_ch();

  // typed expectation riding along with the request, sampled at acceptance
  logic          req_has_want;
  sched_result_t req_want;

  // scheduler state as predicted
  id_t    q_ids [QDEPTH];
  svc_t   q_rem [QDEPTH];
  time_t  q_arr [QDEPTH];
  id_t    q_head;
  id_t    q_tail;
  int     q_count;
  quant_t quantum_reg;
  quant_t quantum_left;
  time_t  sched_time;

  sched_result_t sched_expected[$];
  sched_result_t step_out;
  sched_result_t seen_want;

  stim_row_t dir_rows [DIR_ROWS];
  quant_t    phase_quant [PHASES] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd0, 8'd1, 8'd255};
  int        phase_send  [PHASES] = '{0, 87, 0, 19, 0, 87, 0, 19};
  int        phase_recv  [PHASES] = '{0, 0, 87, 19, 0, 0, 87, 19};

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int burst_left = 0;

  round_robin_tick_scheduler_core #(
    .MAX_PROCESSES(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic quant_t live_quantum();
    return (quantum_reg == '0) ? quant_t'(1) : quantum_reg;
  endfunction

  function automatic sched_result_t sched_step(input logic act, input id_t pid,
                                               input svc_t svc);
    sched_result_t r;
    time_t         nxt;
    svc_t          rem;
    r = '0;
    if (act == ACT_ARRIVE) begin
      if (q_count == QDEPTH) begin
        r.queue_full = 1'b1;
      end else begin
        if (q_count == 0) quantum_left = live_quantum();
        q_ids[q_tail] = pid;
        q_rem[q_tail] = (svc == '0) ? svc_t'(1) : svc;
        q_arr[q_tail] = sched_time;
        q_tail = q_tail + 1'b1;
        q_count++;
      end
    end else begin
      nxt = (sched_time == TIME_MAX) ? TIME_MAX : sched_time + 1'b1;
      if (q_count != 0) begin
        rem = (q_rem[q_head] != '0) ? q_rem[q_head] - 1'b1 : '0;
        quantum_left = (quantum_left != '0) ? quantum_left - 1'b1 : '0;
        q_rem[q_head] = rem;
        r.ran = 1'b1;
        r.running_id = q_ids[q_head];
        if (rem == '0) begin
          r.finished = 1'b1;
          r.finish_time = nxt;
          r.turnaround = nxt - q_arr[q_head];
          q_head = q_head + 1'b1;
          q_count--;
          quantum_left = live_quantum();
        end else if (quantum_left == '0) begin
          // quantum used up: head goes to the tail
          q_ids[q_tail] = q_ids[q_head];
          q_rem[q_tail] = rem;
          q_arr[q_tail] = q_arr[q_head];
          q_head = q_head + 1'b1;
          q_tail = q_tail + 1'b1;
          quantum_left = live_quantum();
        end
      end
      sched_time = nxt;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string what, input longint unsigned got,
                              input longint unsigned want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        step_out = sched_step(in_ch.action, in_ch.proc_id, in_ch.service_time);
        sched_expected.push_back(req_has_want ? req_want : step_out);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sched_expected.size() == 0) begin
          log_mismatch("result with no request pending", 1, 0);
        end else begin
          seen_want = sched_expected.pop_front();
          if (out_ch.ran !== seen_want.ran)
            log_mismatch("ran", out_ch.ran, seen_want.ran);
          if (out_ch.running_id !== seen_want.running_id)
            log_mismatch("running_id", out_ch.running_id, seen_want.running_id);
          if (out_ch.finished !== seen_want.finished)
            log_mismatch("finished", out_ch.finished, seen_want.finished);
          if (out_ch.finish_time !== seen_want.finish_time)
            log_mismatch("finish_time", out_ch.finish_time, seen_want.finish_time);
          if (out_ch.turnaround !== seen_want.turnaround)
            log_mismatch("turnaround", out_ch.turnaround, seen_want.turnaround);
          if (out_ch.queue_full !== seen_want.queue_full)
            log_mismatch("queue_full", out_ch.queue_full, seen_want.queue_full);
        end
      end
    end
  end

  // valid stays high on return so back-to-back requests need no second assignment
  task automatic push_request(input logic act, input id_t pid, input svc_t svc,
                              input logic has_want, input sched_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.proc_id      <= pid;
    in_ch.service_time <= svc;
    req_has_want       <= has_want;
    req_want           <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sched_expected.size() != 0) @(posedge clk);
    // wait quietly before the register write
    repeat (4) @(posedge clk);
  endtask

  task automatic set_quantum(input quant_t q);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we    <= 1'b0;
    quantum_reg = q;
  endtask

  task automatic random_items(input int n);
    logic act;
    int   pick;
    svc_t svc;
    for (int i = 0; i < n; i++) begin
      // occasional arrival bursts can fill the queue past its depth
      if (burst_left == 0 && $urandom_range(199) == 0) burst_left = $urandom_range(24, 4);
      if (burst_left != 0) begin
        act = ACT_ARRIVE;
        burst_left--;
      end else begin
        act = ($urandom_range(99) < ((q_count == 0) ? 50 : 6)) ? ACT_ARRIVE : ACT_TICK;
      end
      pick = $urandom_range(99);
      if (pick < 85) svc = svc_t'($urandom_range(6));
      else if (pick < 98) svc = svc_t'($urandom_range(100, 7));
      else svc = svc_t'($urandom_range(1023));
      push_request(act, id_t'($urandom_range(15)), svc, 1'b0, '0);
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    sched_result_t done_row;
    sched_result_t full_row;
    quant_t        q;

    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_TICK;
    in_ch.proc_id      = '0;
    in_ch.service_time = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_has_want       = 1'b0;
    req_want           = '0;
    rst_n              = 1'b0;

    q_head       = '0;
    q_tail       = '0;
    q_count      = 0;
    quantum_reg  = 8'd1;
    quantum_left = 8'd1;
    sched_time   = '0;

    done_row = '0;
    done_row.ran = 1'b1;
    done_row.running_id = 4'd15;
    done_row.finished = 1'b1;
    done_row.finish_time = 16'd2;
    done_row.turnaround = 16'd1;
    full_row = '0;
    full_row.queue_full = 1'b1;

    // idle tick, zero-work arrival done in one tick, wide job, rotation, then overflow
    dir_rows[0] = '{ACT_TICK,   4'd0,  10'd0,    1'b1, '0};
    dir_rows[1] = '{ACT_ARRIVE, 4'd15, 10'd0,    1'b1, '0};
    dir_rows[2] = '{ACT_TICK,   4'd5,  10'h3ff,  1'b1, done_row};
    dir_rows[3] = '{ACT_ARRIVE, 4'd0,  10'd1023, 1'b1, '0};
    dir_rows[4] = '{ACT_ARRIVE, 4'd1,  10'd2,    1'b1, '0};
    for (int k = 5; k < 9; k++)
      dir_rows[k] = '{ACT_TICK, id_t'(k), svc_t'(k), 1'b0, '0};
    for (int k = 1; k < 16; k++)
      dir_rows[8 + k] = '{ACT_ARRIVE, id_t'(k), svc_t'(k), 1'b1, '0};
    dir_rows[24] = '{ACT_ARRIVE, 4'd7, 10'd5, 1'b1, full_row};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++)
      push_request(dir_rows[k].action, dir_rows[k].proc_id, dir_rows[k].service_time,
                   dir_rows[k].has_want, dir_rows[k].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      q = (p == 5) ? quant_t'($urandom_range(254, 4)) : phase_quant[p];
      set_quantum(q);
      random_items(PHASE_ITEMS);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && sched_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rrts_pkg.sv
rtl/rrts_in_if.sv
rtl/rrts_out_if.sv
rtl/round_robin_tick_scheduler_core.sv
verif/round_robin_tick_scheduler_core_test.sv
